// File: design/alli_pkg.sv
package alli_pkg;

    localparam int SLOTS       = 16;
    localparam int VALUE_WIDTH = 16;
    localparam int SLOT_W      = 5;
    localparam int POS_W       = 5;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_READ   = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_OVERFLOW = 2'd1,
        STATUS_EMPTY    = 2'd2
    } t_status;

    typedef struct packed {
        logic                   func;
        logic [VALUE_WIDTH-1:0] item_value;
        logic [POS_W-1:0]       position;
    } t_in;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] node_value;
        logic [SLOT_W-1:0]      node_slot;
        logic [1:0]             status;
        logic                   last_of_run;
    } t_out;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_OVF,
        OP_HEAD_INS,
        OP_WALK_START,
        OP_WALK_STEP,
        OP_SPLICE,
        OP_LINK_EMIT,
        OP_EMPTY,
        OP_RD_START,
        OP_RD_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   rd_free;   // link read port addressed by free head, else by walk pointer
    } t_cmd;

    typedef struct packed {
        logic func;
        logic free_null;
        logic head_null;
        logic pos_le1;
        logic walk_go;
        logic rd_last;
        logic out_free;
    } t_dp_status;

    // slot numbers are 1-based, slot 0 is null
    function automatic logic [IDX_W-1:0] slot_idx(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] d;
        d = s - SLOT_W'(1);
        return d[IDX_W-1:0];
    endfunction

endpackage

// File: design/alli_ctrl.sv
module alli_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  alli_pkg::t_dp_status  i_status,
    output logic                  o_in_stall,
    output alli_pkg::t_cmd        o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_WALK,
        ST_LINK,
        ST_READ
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd.op      = alli_pkg::OP_NONE;
        o_cmd.rd_free = (r_state == ST_DISPATCH);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = alli_pkg::OP_LOAD;
                    n_state  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (i_status.func == alli_pkg::FUNC_INSERT) begin
                    priority if (i_status.free_null) begin
                        if (i_status.out_free) begin
                            o_cmd.op = alli_pkg::OP_OVF;
                            n_state  = ST_IDLE;
                        end
                    end else if (i_status.pos_le1 || i_status.head_null) begin
                        if (i_status.out_free) begin
                            o_cmd.op = alli_pkg::OP_HEAD_INS;
                            n_state  = ST_IDLE;
                        end
                    end else begin
                        o_cmd.op = alli_pkg::OP_WALK_START;
                        n_state  = ST_WALK;
                    end
                end else begin
                    if (i_status.head_null) begin
                        if (i_status.out_free) begin
                            o_cmd.op = alli_pkg::OP_EMPTY;
                            n_state  = ST_IDLE;
                        end
                    end else begin
                        o_cmd.op = alli_pkg::OP_RD_START;
                        n_state  = ST_READ;
                    end
                end
            end
            ST_WALK: begin
                if (i_status.walk_go) begin
                    o_cmd.op = alli_pkg::OP_WALK_STEP;
                end else begin
                    o_cmd.op = alli_pkg::OP_SPLICE;
                    n_state  = ST_LINK;
                end
            end
            ST_LINK: begin
                if (i_status.out_free) begin
                    o_cmd.op = alli_pkg::OP_LINK_EMIT;
                    n_state  = ST_IDLE;
                end
            end
            ST_READ: begin
                if (i_status.out_free) begin
                    o_cmd.op = alli_pkg::OP_RD_EMIT;
                    if (i_status.rd_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: design/alli_dp.sv
module alli_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  alli_pkg::t_cmd        i_cmd,
    input  alli_pkg::t_in         i_in_data,
    input  logic                  i_out_stall,
    output alli_pkg::t_dp_status  o_status,
    output logic                  o_out_valid,
    output alli_pkg::t_out        o_out_data
);

    alli_pkg::t_in                     r_in;
    logic [alli_pkg::SLOT_W-1:0]       r_head;
    logic [alli_pkg::SLOT_W-1:0]       r_free;
    logic [alli_pkg::SLOT_W-1:0]       r_ptr;
    logic [alli_pkg::SLOT_W-1:0]       r_slot;
    logic [alli_pkg::POS_W-1:0]        r_k;
    logic [alli_pkg::CNT_W-1:0]        r_cnt;
    logic [alli_pkg::SLOT_W-1:0]       r_link  [alli_pkg::SLOTS];
    logic [alli_pkg::VALUE_WIDTH-1:0]  r_value [alli_pkg::SLOTS];
    logic                              r_out_valid;
    logic                              n_out_valid;
    alli_pkg::t_out                    r_out;

    logic [alli_pkg::SLOT_W-1:0]       w_rd_addr;
    logic [alli_pkg::SLOT_W-1:0]       w_link_rd;
    logic                              w_out_free;
    logic                              w_rd_last;

    // single link read port: free head while dispatching, walk pointer otherwise
    assign w_rd_addr  = i_cmd.rd_free ? r_free : r_ptr;
    assign w_link_rd  = r_link[alli_pkg::slot_idx(w_rd_addr)];
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_rd_last  = (w_link_rd == '0) ||
                        (r_cnt == alli_pkg::CNT_W'(alli_pkg::SLOTS - 1));

    always_comb begin
        o_status.func      = r_in.func;
        o_status.free_null = (r_free == '0);
        o_status.head_null = (r_head == '0);
        o_status.pos_le1   = (r_in.position <= alli_pkg::POS_W'(1));
        o_status.walk_go   = (r_k > alli_pkg::POS_W'(2)) && (w_link_rd != '0) &&
                             (r_cnt < alli_pkg::CNT_W'(alli_pkg::SLOTS));
        o_status.rd_last   = w_rd_last;
        o_status.out_free  = w_out_free;
    end

    // output beat is loaded by any emitting op, otherwise it drops once taken
    always_comb begin
        unique case (i_cmd.op)
            alli_pkg::OP_OVF, alli_pkg::OP_EMPTY, alli_pkg::OP_HEAD_INS,
            alli_pkg::OP_LINK_EMIT, alli_pkg::OP_RD_EMIT: begin
                n_out_valid = 1'b1;
            end
            default: begin
                n_out_valid = r_out_valid && i_out_stall;
            end
        endcase
    end

    // list pointers, link store and output valid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_free      <= alli_pkg::SLOT_W'(1);
            r_out_valid <= 1'b0;
            for (int i = 0; i < alli_pkg::SLOTS; i++) begin
                r_link[i] <= (i < alli_pkg::SLOTS - 1) ? alli_pkg::SLOT_W'(i + 2) : '0;
            end
        end else begin
            r_out_valid <= n_out_valid;
            unique case (i_cmd.op)
                alli_pkg::OP_LINK_EMIT: begin
                    r_link[alli_pkg::slot_idx(r_ptr)] <= r_slot;
                end
                alli_pkg::OP_HEAD_INS: begin
                    r_free      <= w_link_rd;
                    r_head      <= r_free;
                    r_link[alli_pkg::slot_idx(r_free)] <= r_head;
                end
                alli_pkg::OP_WALK_START: begin
                    r_free <= w_link_rd;
                end
                alli_pkg::OP_SPLICE: begin
                    r_link[alli_pkg::slot_idx(r_slot)] <= w_link_rd;
                end
                default: begin
                end
            endcase
        end
    end

    // value store, work registers and output beat data, no reset
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            alli_pkg::OP_LOAD: begin
                r_in <= i_in_data;
            end
            alli_pkg::OP_OVF: begin
                r_out.node_value  <= r_in.item_value;
                r_out.node_slot   <= '0;
                r_out.status      <= alli_pkg::STATUS_OVERFLOW;
                r_out.last_of_run <= 1'b1;
            end
            alli_pkg::OP_HEAD_INS: begin
                r_value[alli_pkg::slot_idx(r_free)] <= r_in.item_value;
                r_out.node_value  <= r_in.item_value;
                r_out.node_slot   <= r_free;
                r_out.status      <= alli_pkg::STATUS_OK;
                r_out.last_of_run <= 1'b1;
            end
            alli_pkg::OP_WALK_START: begin
                r_value[alli_pkg::slot_idx(r_free)] <= r_in.item_value;
                r_slot <= r_free;
                r_ptr  <= r_head;
                r_k    <= r_in.position;
                r_cnt  <= '0;
            end
            alli_pkg::OP_WALK_STEP: begin
                r_ptr <= w_link_rd;
                r_k   <= r_k - alli_pkg::POS_W'(1);
                r_cnt <= r_cnt + alli_pkg::CNT_W'(1);
            end
            alli_pkg::OP_LINK_EMIT: begin
                r_out.node_value  <= r_in.item_value;
                r_out.node_slot   <= r_slot;
                r_out.status      <= alli_pkg::STATUS_OK;
                r_out.last_of_run <= 1'b1;
            end
            alli_pkg::OP_EMPTY: begin
                r_out.node_value  <= '0;
                r_out.node_slot   <= '0;
                r_out.status      <= alli_pkg::STATUS_EMPTY;
                r_out.last_of_run <= 1'b1;
            end
            alli_pkg::OP_RD_START: begin
                r_ptr <= r_head;
                r_cnt <= '0;
            end
            alli_pkg::OP_RD_EMIT: begin
                r_out.node_value  <= r_value[alli_pkg::slot_idx(r_ptr)];
                r_out.node_slot   <= r_ptr;
                r_out.status      <= alli_pkg::STATUS_OK;
                r_out.last_of_run <= w_rd_last;
                r_ptr <= w_link_rd;
                r_cnt <= r_cnt + alli_pkg::CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: design/array_linked_list_insert_top.sv
// Insert: accept, dispatch, then one link walked per cycle (at most SLOTS-2), then splice and
//   link; head insert or overflow loads its output beat from the dispatch state.
// Read out: accept, dispatch, then one beat per list node (up to SLOTS) each cycle that the
//   output is free. One item at a time: the input stays stalled until the item's last
//   output beat is loaded, and so also while the output is stalled.
// Synchronous active-low reset: empty list, free chain 1..SLOTS, no output beat pending.
module array_linked_list_insert_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  alli_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output alli_pkg::t_out  o_out_data
);

    alli_pkg::t_cmd        w_cmd;
    alli_pkg::t_dp_status  w_status;

    alli_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    alli_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// File: tb/alli_list_checker.sv
module alli_list_checker
    import alli_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow copy of the list stores; slot 0 is the null link
    logic [VALUE_WIDTH-1:0] value_mem [1:SLOTS];
    logic [SLOT_W-1:0]      link_mem  [0:SLOTS];
    logic [SLOT_W-1:0]      head_ptr;
    logic [SLOT_W-1:0]      free_ptr;

    t_out node_due_q[$];
    int   fail_cnt;

    function automatic void clear_list();
        for (int s = 0; s <= SLOTS; s++) begin
            link_mem[s] = (s == 0 || s == SLOTS) ? '0 : SLOT_W'(s + 1);
        end
        for (int s = 1; s <= SLOTS; s++) begin
            value_mem[s] = '0;
        end
        head_ptr = '0;
        free_ptr = SLOT_W'(1);
    endfunction

    function automatic void predict_insert(input t_in beat);
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] walk;
        int                k;
        int                steps;
        t_out              res;
        slot            = free_ptr;
        res.node_value  = beat.item_value;
        res.last_of_run = 1'b1;
        if (slot == '0) begin
            res.node_slot = '0;
            res.status    = STATUS_OVERFLOW;
        end else begin
            free_ptr        = link_mem[slot];
            value_mem[slot] = beat.item_value;
            if (beat.position <= 1 || head_ptr == '0) begin
                link_mem[slot] = head_ptr;
                head_ptr       = slot;
            end else begin
                // stop on the node at position-1, or on the tail if the list is shorter
                walk  = head_ptr;
                k     = beat.position;
                steps = 0;
                while (k > 2 && link_mem[walk] != '0 && steps < SLOTS) begin
                    walk = link_mem[walk];
                    k--;
                    steps++;
                end
                link_mem[slot] = link_mem[walk];
                link_mem[walk] = slot;
            end
            res.node_slot = slot;
            res.status    = STATUS_OK;
        end
        node_due_q.push_back(res);
    endfunction

    function automatic void predict_readout();
        logic [SLOT_W-1:0] cur;
        logic [SLOT_W-1:0] nxt;
        int                n;
        t_out              res;
        cur = head_ptr;
        n   = 0;
        if (cur == '0) begin
            res.node_value  = '0;
            res.node_slot   = '0;
            res.status      = STATUS_EMPTY;
            res.last_of_run = 1'b1;
            node_due_q.push_back(res);
        end else begin
            while (cur != '0 && n < SLOTS) begin
                nxt             = link_mem[cur];
                res.node_value  = value_mem[cur];
                res.node_slot   = cur;
                res.status      = STATUS_OK;
                res.last_of_run = (nxt == '0) || (n + 1 >= SLOTS);
                node_due_q.push_back(res);
                n++;
                cur = nxt;
            end
        end
    endfunction

    function automatic void check_node(input t_out got);
        t_out want;
        if (node_due_q.size() == 0) begin
            $error("unexpected output beat: value %0h slot %0d status %0d last %0b",
                   got.node_value, got.node_slot, got.status, got.last_of_run);
            fail_cnt++;
            return;
        end
        want = node_due_q.pop_front();
        if (got.node_value !== want.node_value) begin
            $error("node_value: expected %0h, got %0h", want.node_value, got.node_value);
            fail_cnt++;
        end
        if (got.node_slot !== want.node_slot) begin
            $error("node_slot: expected %0d, got %0d", want.node_slot, got.node_slot);
            fail_cnt++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_cnt++;
        end
        if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
            fail_cnt++;
        end
    endfunction

    initial begin
        fail_cnt     = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_list();
            node_due_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.func == FUNC_INSERT) begin
                    predict_insert(i_in_data);
                end else begin
                    predict_readout();
                end
            end
            if (i_out_valid && !i_out_stall) begin
                check_node(i_out_data);
            end
        end
        o_pending    <= node_due_q.size();
        o_fail_count <= fail_cnt;
    end

endmodule

// File: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import alli_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_ITEMS     = 200;
    localparam int LONG_HOLD_AT     = 60;
    localparam int LONG_HOLD_CYCLES = 300;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    t_out out_data;
    logic calm      = 1'b0;   // no random idling on either side while set
    int   fail_count;
    int   pending;
    int   cycles    = 0;

    array_linked_list_insert_top u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    alli_list_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("array_linked_list_insert_top test failed");
            $finish;
        end
    end

    task automatic send_item(input t_func f, input logic [VALUE_WIDTH-1:0] v,
                             input logic [POS_W-1:0] p);
        int  gap;
        t_in beat;
        beat.func       = f;
        beat.item_value = v;
        beat.position   = p;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (!(in_valid && !in_stall));
    endtask

    // drops valid in the step of the last accepted beat, then waits until no expected beat is pending
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic run_directed();
        logic [POS_W-1:0] fill_pos [0:9];
        fill_pos = '{5'd3, 5'd6, 5'd9, 5'd31, 5'd2, 5'd10, 5'd12, 5'd1, 5'd16, 5'd5};
        send_item(FUNC_READ,   16'h0000, 5'd0);    // empty list
        send_item(FUNC_INSERT, 16'h0000, 5'd7);    // empty list, any position goes to head
        send_item(FUNC_INSERT, 16'hFFFF, 5'd0);
        send_item(FUNC_INSERT, 16'h1234, 5'd1);
        send_item(FUNC_INSERT, 16'hABCD, 5'd31);   // past the end: append
        send_item(FUNC_INSERT, 16'h5555, 5'd2);
        send_item(FUNC_INSERT, 16'hAAAA, 5'd4);
        send_item(FUNC_READ,   16'hFFFF, 5'd31);
        for (int k = 0; k < 10; k++) begin
            send_item(FUNC_INSERT, 16'($urandom), fill_pos[k]);
        end
        // store is full now
        send_item(FUNC_INSERT, 16'hFFFF, 5'd31);
        send_item(FUNC_INSERT, 16'h0000, 5'd0);
        send_item(FUNC_READ,   16'h8001, 5'd17);
    endtask

    task automatic run_random();
        t_func f;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 25 == 0) begin
                calm <= ($urandom_range(0, 3) == 0);
            end
            if (k == RANDOM_ITEMS / 2) begin
                drain_results();
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            f = $urandom_range(0, 1) ? FUNC_READ : FUNC_INSERT;
            send_item(f, 16'($urandom), 5'($urandom));
        end
    endtask

    // output side: random stall per beat, one long hold to back up the block
    initial begin
        int hold;
        int beats;
        beats = 0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (beats == LONG_HOLD_AT) begin
                hold = LONG_HOLD_CYCLES;
            end else begin
                hold = calm ? 0 : $urandom_range(0, 8);
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
            beats++;
        end
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        drain_results();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("array_linked_list_insert_top test passed");
        end else begin
            $display("array_linked_list_insert_top test failed");
        end
        $finish;
    end

endmodule
